// ===== hdl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C register-access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int MAX_READ_BYTES = 16;
  localparam int IN_CNT_W       = 5;
  localparam int CNT_W          = $clog2(MAX_READ_BYTES + 1);

  // input queue between front and engine
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [15:0] HALF_RESET    = 16'd50;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic REG_HALF    = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [15:0] {
    P_IDLE = 16'h0001,
    P_RS0  = 16'h0002,
    P_ST1  = 16'h0004,
    P_ST2  = 16'h0008,
    P_TXL  = 16'h0010,
    P_TXH  = 16'h0020,
    P_AKL  = 16'h0040,
    P_AKH  = 16'h0080,
    P_AKW  = 16'h0100,
    P_RXL  = 16'h0200,
    P_RXH  = 16'h0400,
    P_MAL  = 16'h0800,
    P_MAH  = 16'h1000,
    P_SP0  = 16'h2000,
    P_SP1  = 16'h4000,
    P_SP2  = 16'h8000
  } phase_t;

  typedef enum logic [1:0] {
    S_ADDRW = 2'd0,
    S_REG   = 2'd1,
    S_DATA  = 2'd2,
    S_ADDRR = 2'd3
  } stage_t;

  typedef struct packed {
    logic             req_start;
    logic             func;
    logic [6:0]       slave_addr;
    logic [7:0]       sub_addr;
    logic [7:0]       write_data;
    logic [CNT_W-1:0] read_count;  // already clamped to 1..MAX_READ_BYTES
    logic             sda_in;
  } item_t;

  typedef struct packed {
    logic [15:0] half_ticks;
    logic [15:0] ack_timeout;
  } cfg_t;

endpackage

// ===== hdl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick items, clamps the read count and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_start,
  input  logic                         in_func,
  input  logic [6:0]                   in_slave_addr,
  input  logic [7:0]                   in_sub_addr,
  input  logic [7:0]                   in_write_data,
  input  logic [i2cm_pkg::IN_CNT_W-1:0] in_read_count,
  input  logic                         in_sda_in,
  output i2cm_pkg::item_t              head_item,
  output logic                         head_valid,
  input  logic                         pop
);
  import i2cm_pkg::*;

  item_t             entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  item_t             new_item;
  logic [CNT_W-1:0]  cnt_clamped;
  logic              push;

  always_comb begin
    if (in_read_count == '0) begin
      cnt_clamped = CNT_W'(1);
    end else if (int'(in_read_count) > MAX_READ_BYTES) begin
      cnt_clamped = CNT_W'(MAX_READ_BYTES);
    end else begin
      cnt_clamped = CNT_W'(in_read_count);
    end
    new_item.req_start  = in_req_start;
    new_item.func       = in_func;
    new_item.slave_addr = in_slave_addr;
    new_item.sub_addr   = in_sub_addr;
    new_item.write_data = in_write_data;
    new_item.read_count = cnt_clamped;
    new_item.sda_in     = in_sda_in;
  end

  assign in_stall   = (count_r == QCNT_W'(QDEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count_r != '0);
  assign head_item  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== hdl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: advances one tick per queued item and registers the result.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  i2cm_pkg::cfg_t  cfg,
  input  i2cm_pkg::item_t head_item,
  input  logic            head_valid,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_scl_out,
  output logic            out_sda_drive_low,
  output logic            out_busy_res,
  output logic [7:0]      out_read_data,
  output logic            out_read_valid,
  output logic            out_read_last,
  output logic            out_done_res,
  output logic            out_status
);
  import i2cm_pkg::*;

  phase_t           phase_r, phase_nxt;
  stage_t           stage_r, stage_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic [15:0]      ack_timer_r, ack_timer_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [CNT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic             nack_r, nack_nxt;
  logic             func_r, func_nxt;
  logic [6:0]       dev_r, dev_nxt;
  logic [7:0]       reg_r, reg_nxt;
  logic [7:0]       data_r, data_nxt;

  logic             out_valid_r;
  logic             scl_r, sdal_r, busy_r, rvalid_r, rlast_r, done_r, stat_r;
  logic [7:0]       rdata_r;

  logic             scl, sdal, busy, rvalid, rlast, done, stat;
  logic [7:0]       rdata;
  logic [15:0]      half;
  logic [16:0]      tick_inc;
  logic             half_hit;
  logic [15:0]      timer_inc;
  logic             txbit, mbit;
  logic             do_ack;
  logic [7:0]       rx_shift;

  assign pop = head_valid && (!out_valid_r || !out_stall);

  always_comb begin
    half      = (cfg.half_ticks == '0) ? 16'd1 : cfg.half_ticks;
    tick_inc  = {1'b0, tick_r} + 17'd1;
    half_hit  = (tick_inc >= {1'b0, half});
    timer_inc = (ack_timer_r == 16'hffff) ? ack_timer_r : ack_timer_r + 16'd1;
    txbit     = ~shift_r[7];
    mbit      = (bytes_left_r > CNT_W'(1));
    rx_shift  = {shift_r[6:0], head_item.sda_in};

    // line levels come from the phase before this tick's update
    scl  = 1'b1;
    sdal = 1'b0;
    busy = 1'b1;
    unique case (phase_r)
      P_IDLE: begin scl = 1'b1; sdal = 1'b0; busy = 1'b0; end
      P_RS0:  begin scl = 1'b0; sdal = 1'b0; end
      P_ST1:  begin scl = 1'b1; sdal = 1'b0; end
      P_ST2:  begin scl = 1'b1; sdal = 1'b1; end
      P_TXL:  begin scl = 1'b0; sdal = txbit; end
      P_TXH:  begin scl = 1'b1; sdal = txbit; end
      P_AKL:  begin scl = 1'b0; sdal = 1'b0; end
      P_AKH, P_AKW: begin scl = 1'b1; sdal = 1'b0; end
      P_RXL:  begin scl = 1'b0; sdal = 1'b0; end
      P_RXH:  begin scl = 1'b1; sdal = 1'b0; end
      P_MAL:  begin scl = 1'b0; sdal = mbit; end
      P_MAH:  begin scl = 1'b1; sdal = mbit; end
      P_SP0:  begin scl = 1'b0; sdal = 1'b1; end
      P_SP1:  begin scl = 1'b1; sdal = 1'b1; end
      default: begin scl = 1'b1; sdal = 1'b0; end
    endcase

    rdata  = 8'd0;
    rvalid = 1'b0;
    rlast  = 1'b0;
    done   = 1'b0;
    stat   = 1'b0;
    do_ack = 1'b0;

    phase_nxt      = phase_r;
    stage_nxt      = stage_r;
    tick_nxt       = tick_r;
    ack_timer_nxt  = ack_timer_r;
    bit_nxt        = bit_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    nack_nxt       = nack_r;
    func_nxt       = func_r;
    dev_nxt        = dev_r;
    reg_nxt        = reg_r;
    data_nxt       = data_r;

    unique case (phase_r)
      P_IDLE: begin
        if (head_item.req_start) begin
          func_nxt       = head_item.func;
          dev_nxt        = head_item.slave_addr;
          reg_nxt        = head_item.sub_addr;
          data_nxt       = head_item.write_data;
          bytes_left_nxt = head_item.read_count;
          stage_nxt      = S_ADDRW;
          nack_nxt       = 1'b0;
          ack_timer_nxt  = '0;
          busy           = 1'b1;
          phase_nxt      = P_ST1;
          tick_nxt       = '0;
        end
      end
      P_AKW: begin
        if (!head_item.sda_in) begin
          do_ack = 1'b1;
        end else begin
          ack_timer_nxt = timer_inc;
          if (timer_inc >= cfg.ack_timeout) begin
            nack_nxt  = 1'b1;
            phase_nxt = P_SP0;
            tick_nxt  = '0;
          end
        end
      end
      default: begin
        tick_nxt = tick_inc[15:0];
        if (half_hit) begin
          tick_nxt = '0;
          unique case (phase_r)
            P_RS0: phase_nxt = P_ST1;
            P_ST1: phase_nxt = P_ST2;
            P_ST2: begin
              shift_nxt = {dev_r, (stage_r == S_ADDRR)};
              bit_nxt   = '0;
              phase_nxt = P_TXL;
            end
            P_TXL: phase_nxt = P_TXH;
            P_TXH: begin
              shift_nxt = {shift_r[6:0], 1'b0};
              if (bit_r == 3'd7) begin
                bit_nxt   = '0;
                phase_nxt = P_AKL;
              end else begin
                bit_nxt   = bit_r + 3'd1;
                phase_nxt = P_TXL;
              end
            end
            P_AKL: phase_nxt = P_AKH;
            P_AKH: begin
              if (!head_item.sda_in) begin
                do_ack = 1'b1;
              end else begin
                ack_timer_nxt = '0;
                phase_nxt     = P_AKW;
              end
            end
            P_RXL: phase_nxt = P_RXH;
            P_RXH: begin
              shift_nxt = rx_shift;
              if (bit_r == 3'd7) begin
                bit_nxt   = '0;
                rdata     = rx_shift;
                rvalid    = 1'b1;
                rlast     = (bytes_left_r <= CNT_W'(1));
                phase_nxt = P_MAL;
              end else begin
                bit_nxt   = bit_r + 3'd1;
                phase_nxt = P_RXL;
              end
            end
            P_MAL: phase_nxt = P_MAH;
            P_MAH: begin
              if (bytes_left_r > CNT_W'(1)) begin
                bytes_left_nxt = bytes_left_r - CNT_W'(1);
                shift_nxt      = '0;
                phase_nxt      = P_RXL;
              end else begin
                phase_nxt = P_SP0;
              end
            end
            P_SP0: phase_nxt = P_SP1;
            P_SP1: phase_nxt = P_SP2;
            default: begin
              // end of stop condition
              done           = 1'b1;
              stat           = nack_r;
              nack_nxt       = 1'b0;
              bytes_left_nxt = '0;
              bit_nxt        = '0;
              ack_timer_nxt  = '0;
              stage_nxt      = S_ADDRW;
              phase_nxt      = P_IDLE;
            end
          endcase
        end
      end
    endcase

    // slave acknowledged: pick the next byte of the transaction
    if (do_ack) begin
      tick_nxt = '0;
      unique case (stage_r)
        S_ADDRW: begin
          stage_nxt = S_REG;
          shift_nxt = reg_r;
          bit_nxt   = '0;
          phase_nxt = P_TXL;
        end
        S_REG: begin
          if (func_r == FUNC_WRITE) begin
            stage_nxt = S_DATA;
            shift_nxt = data_r;
            bit_nxt   = '0;
            phase_nxt = P_TXL;
          end else begin
            stage_nxt = S_ADDRR;
            phase_nxt = P_RS0;
          end
        end
        S_ADDRR: begin
          shift_nxt = '0;
          bit_nxt   = '0;
          phase_nxt = P_RXL;
        end
        default: phase_nxt = P_SP0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= P_IDLE;
      stage_r      <= S_ADDRW;
      tick_r       <= '0;
      ack_timer_r  <= '0;
      bit_r        <= '0;
      shift_r      <= '0;
      bytes_left_r <= '0;
      nack_r       <= 1'b0;
      func_r       <= 1'b0;
      dev_r        <= '0;
      reg_r        <= '0;
      data_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        phase_r      <= phase_nxt;
        stage_r      <= stage_nxt;
        tick_r       <= tick_nxt;
        ack_timer_r  <= ack_timer_nxt;
        bit_r        <= bit_nxt;
        shift_r      <= shift_nxt;
        bytes_left_r <= bytes_left_nxt;
        nack_r       <= nack_nxt;
        func_r       <= func_nxt;
        dev_r        <= dev_nxt;
        reg_r        <= reg_nxt;
        data_r       <= data_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      scl_r    <= scl;
      sdal_r   <= sdal;
      busy_r   <= busy;
      rdata_r  <= rdata;
      rvalid_r <= rvalid;
      rlast_r  <= rlast;
      done_r   <= done;
      stat_r   <= stat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scl_out       = scl_r;
  assign out_sda_drive_low = sdal_r;
  assign out_busy_res      = busy_r;
  assign out_read_data     = rdata_r;
  assign out_read_valid    = rvalid_r;
  assign out_read_last     = rlast_r;
  assign out_done_res      = done_r;
  assign out_status        = stat_r;

endmodule

// ===== hdl/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access
// I2C master running register write and burst read transactions.
// ----------------------------------------------------------------------------
// Each input item is one tick of the bus engine and yields exactly one result
// item with the SCL/SDA levels of that tick plus read and done strobes. One
// item is taken per clock cycle while the queue is not full; it waits in a
// two-entry input queue and its result is loaded into the output register at
// the edge at which the engine takes it from the queue head, so the sustained
// rate is one item per cycle while the output does not stall.
// The queue absorbs output stalls. Two registers on the configuration port,
// half_period_ticks at address 0 and ack_timeout_ticks at address 4, which the
// user must write only while no transaction runs; the block never checks.
module i2c_master_register_access (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_start,
  input  logic                          in_func,
  input  logic [6:0]                    in_slave_addr,
  input  logic [7:0]                    in_sub_addr,
  input  logic [7:0]                    in_write_data,
  input  logic [i2cm_pkg::IN_CNT_W-1:0] in_read_count,
  input  logic                          in_sda_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_scl_out,
  output logic                          out_sda_drive_low,
  output logic                          out_busy_res,
  output logic [7:0]                    out_read_data,
  output logic                          out_read_valid,
  output logic                          out_read_last,
  output logic                          out_done_res,
  output logic                          out_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cm_pkg::CFG_AW-1:0]   paddr,
  input  logic [i2cm_pkg::CFG_DW-1:0]   pwdata,
  output logic [i2cm_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import i2cm_pkg::*;

  logic [15:0] half_r;
  logic [15:0] timeout_r;
  cfg_t        cfg;
  item_t       head_item;
  logic        head_valid;
  logic        pop;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= HALF_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_HALF:    half_r    <= pwdata[15:0];
        REG_TIMEOUT: timeout_r <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HALF:    prdata = {{(CFG_DW - 16){1'b0}}, half_r};
      REG_TIMEOUT: prdata = {{(CFG_DW - 16){1'b0}}, timeout_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg.half_ticks  = half_r;
  assign cfg.ack_timeout = timeout_r;

  i2cm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_start  (in_req_start),
    .in_func       (in_func),
    .in_slave_addr (in_slave_addr),
    .in_sub_addr   (in_sub_addr),
    .in_write_data (in_write_data),
    .in_read_count (in_read_count),
    .in_sda_in     (in_sda_in),
    .head_item     (head_item),
    .head_valid    (head_valid),
    .pop           (pop)
  );

  i2cm_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .head_item         (head_item),
    .head_valid        (head_valid),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scl_out       (out_scl_out),
    .out_sda_drive_low (out_sda_drive_low),
    .out_busy_res      (out_busy_res),
    .out_read_data     (out_read_data),
    .out_read_valid    (out_read_valid),
    .out_read_last     (out_read_last),
    .out_done_res      (out_done_res),
    .out_status        (out_status)
  );

endmodule

// ===== hdl/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result channel of the I2C master.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_scl_out,
  input logic       out_sda_drive_low,
  input logic       out_busy_res,
  input logic [7:0] out_read_data,
  input logic       out_read_valid,
  input logic       out_read_last,
  input logic       out_done_res,
  input logic       out_status
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data)
      && $stable(out_done_res) && $stable(out_scl_out))
    else $error("result payload changed while stalled");

  // while idle the bus is released
  a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_scl_out && !out_sda_drive_low)
    else $error("bus driven while idle");

  // status only reported when the transaction finishes
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_done_res && out_busy_res)
    else $error("status without done");

  // last marker only with a received byte, sampled with scl high
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_last |-> out_read_valid && out_scl_out && !out_done_res)
    else $error("read_last without read_valid");

endmodule

bind i2c_master_register_access i2cm_checker u_checker (.*);

// ===== test/i2c_master_register_access_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_register_access_test
// Self-checking bench for the I2C register-access master.
// ----------------------------------------------------------------------------
// Every accepted input transaction is one engine tick. A cycle-level model of
// the bus sequencer in the scoreboard predicts the SCL/SDA levels and strobes
// of each tick, and every output transaction is compared field by field.
// Directed requests hit the field extremes, count clamping, requests while
// busy and ACK timeouts; randomized phases then sweep the timing registers,
// including zero and full-scale values, with random SDA responses and random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------

import i2cm_pkg::*;

typedef struct packed {
  logic       req_start;
  logic       func;
  logic [6:0] slave_addr;
  logic [7:0] sub_addr;
  logic [7:0] write_data;
  logic [4:0] read_count;
  logic       sda_in;
} tick_in_t;

typedef struct packed {
  logic       scl;
  logic       sda_low;
  logic       busy;
  logic [7:0] rdata;
  logic       rvalid;
  logic       rlast;
  logic       done;
  logic       status;
} bus_levels_t;

class bus_scoreboard;
  logic [15:0] half_ticks;
  logic [15:0] ack_limit;
  phase_t      phase;
  stage_t      stage;
  int unsigned tick_cnt;
  int unsigned ack_cnt;
  int unsigned bit_idx;
  int unsigned bytes_left;
  logic [7:0]  shift;
  logic        rq_func;
  logic [6:0]  rq_dev;
  logic [7:0]  rq_reg;
  logic [7:0]  rq_data;
  logic        nack;
  bus_levels_t expected_levels[$];
  int unsigned mismatches;
  int unsigned ticks_checked;
  int unsigned writes_taken;
  int unsigned reads_taken;
  int unsigned nacks_seen;
  int unsigned bytes_read;

  function new();
    half_ticks    = HALF_RESET;
    ack_limit     = TIMEOUT_RESET;
    phase         = P_IDLE;
    stage         = S_ADDRW;
    tick_cnt      = 0;
    ack_cnt       = 0;
    bit_idx       = 0;
    bytes_left    = 0;
    shift         = '0;
    rq_func       = FUNC_WRITE;
    rq_dev        = '0;
    rq_reg        = '0;
    rq_data       = '0;
    nack          = 1'b0;
    mismatches    = 0;
    ticks_checked = 0;
    writes_taken  = 0;
    reads_taken   = 0;
    nacks_seen    = 0;
    bytes_read    = 0;
  endfunction

  function void set_config(logic idx, logic [15:0] value);
    if (idx == REG_HALF) begin
      half_ticks = value;
    end else begin
      ack_limit = value;
    end
  endfunction

  function void enter(phase_t p);
    phase    = p;
    tick_cnt = 0;
  endfunction

  function void load_byte(logic [7:0] b);
    shift   = b;
    bit_idx = 0;
    enter(P_TXL);
  endfunction

  function void byte_acked();
    case (stage)
      S_ADDRW: begin
        stage = S_REG;
        load_byte(rq_reg);
      end
      S_REG: begin
        if (rq_func == FUNC_WRITE) begin
          stage = S_DATA;
          load_byte(rq_data);
        end else begin
          stage = S_ADDRR;
          enter(P_RS0);
        end
      end
      S_ADDRR: begin
        shift   = '0;
        bit_idx = 0;
        enter(P_RXL);
      end
      default: enter(P_SP0);
    endcase
  endfunction

  // one engine tick: levels come from the phase before the step
  function bus_levels_t advance(tick_in_t t);
    bus_levels_t r;
    int unsigned hp;
    int unsigned cnt;
    logic        txb;
    logic        more;
    r      = '0;
    r.scl  = 1'b1;
    r.busy = 1'b1;
    hp     = (half_ticks == 0) ? 1 : half_ticks;
    txb    = ~shift[7];
    more   = (bytes_left > 1);
    case (phase)
      P_IDLE: r.busy = 1'b0;
      P_RS0, P_AKL, P_RXL: r.scl = 1'b0;
      P_ST2, P_SP1: r.sda_low = 1'b1;
      P_TXL: begin
        r.scl     = 1'b0;
        r.sda_low = txb;
      end
      P_TXH: r.sda_low = txb;
      P_MAL: begin
        r.scl     = 1'b0;
        r.sda_low = more;
      end
      P_MAH: r.sda_low = more;
      P_SP0: begin
        r.scl     = 1'b0;
        r.sda_low = 1'b1;
      end
      default: ;
    endcase

    if (phase == P_IDLE) begin
      if (t.req_start) begin
        cnt = 32'(t.read_count);
        if (cnt == 0) cnt = 1;
        if (cnt > MAX_READ_BYTES) cnt = MAX_READ_BYTES;
        rq_func    = t.func;
        rq_dev     = t.slave_addr;
        rq_reg     = t.sub_addr;
        rq_data    = t.write_data;
        bytes_left = cnt;
        stage      = S_ADDRW;
        nack       = 1'b0;
        ack_cnt    = 0;
        r.busy     = 1'b1;
        if (t.func == FUNC_READ) reads_taken++;
        else writes_taken++;
        enter(P_ST1);
      end
    end else if (phase == P_AKW) begin
      if (!t.sda_in) begin
        byte_acked();
      end else begin
        if (ack_cnt < 16'hffff) ack_cnt++;
        if (ack_cnt >= ack_limit) begin
          nack = 1'b1;
          enter(P_SP0);
        end
      end
    end else begin
      tick_cnt++;
      if (tick_cnt >= hp) begin
        case (phase)
          P_RS0: enter(P_ST1);
          P_ST1: enter(P_ST2);
          P_ST2: load_byte({rq_dev, stage == S_ADDRR});
          P_TXL: enter(P_TXH);
          P_TXH: begin
            shift = shift << 1;
            if (bit_idx >= 7) begin
              bit_idx = 0;
              enter(P_AKL);
            end else begin
              bit_idx++;
              enter(P_TXL);
            end
          end
          P_AKL: enter(P_AKH);
          P_AKH: begin
            if (!t.sda_in) begin
              byte_acked();
            end else begin
              ack_cnt = 0;
              enter(P_AKW);
            end
          end
          P_RXL: enter(P_RXH);
          P_RXH: begin
            shift = {shift[6:0], t.sda_in};
            if (bit_idx >= 7) begin
              bit_idx  = 0;
              r.rdata  = shift;
              r.rvalid = 1'b1;
              r.rlast  = (bytes_left <= 1);
              bytes_read++;
              enter(P_MAL);
            end else begin
              bit_idx++;
              enter(P_RXL);
            end
          end
          P_MAL: enter(P_MAH);
          P_MAH: begin
            if (bytes_left > 1) begin
              bytes_left--;
              shift = '0;
              enter(P_RXL);
            end else begin
              enter(P_SP0);
            end
          end
          P_SP0: enter(P_SP1);
          P_SP1: enter(P_SP2);
          P_SP2: begin
            r.done   = 1'b1;
            r.status = nack;
            if (nack) nacks_seen++;
            nack       = 1'b0;
            bytes_left = 0;
            bit_idx    = 0;
            ack_cnt    = 0;
            stage      = S_ADDRW;
            enter(P_IDLE);
          end
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  function void note_input(tick_in_t t);
    expected_levels.push_back(advance(t));
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: tick %0d %s mismatch, expected %0h, actual %0h",
               $time, ticks_checked, name, want, got);
    end
  endfunction

  function void check_result(bus_levels_t got);
    bus_levels_t want;
    if (expected_levels.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected output transaction, expected none, actual %h", $time, got);
      return;
    end
    want = expected_levels.pop_front();
    compare_field("scl_out", 8'(want.scl), 8'(got.scl));
    compare_field("sda_drive_low", 8'(want.sda_low), 8'(got.sda_low));
    compare_field("busy_res", 8'(want.busy), 8'(got.busy));
    compare_field("read_data", want.rdata, got.rdata);
    compare_field("read_valid", 8'(want.rvalid), 8'(got.rvalid));
    compare_field("read_last", 8'(want.rlast), 8'(got.rlast));
    compare_field("done_res", 8'(want.done), 8'(got.done));
    compare_field("status", 8'(want.status), 8'(got.status));
    ticks_checked++;
  endfunction

  function bit engine_idle();
    return phase == P_IDLE;
  endfunction

  function int pending();
    return expected_levels.size();
  endfunction
endclass

module i2c_master_register_access_test;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int MAX_WAIT    = 17;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_req_start = 1'b0;
  logic                 in_func = 1'b0;
  logic [6:0]           in_slave_addr = '0;
  logic [7:0]           in_sub_addr = '0;
  logic [7:0]           in_write_data = '0;
  logic [IN_CNT_W-1:0]  in_read_count = '0;
  logic                 in_sda_in = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_scl_out;
  logic                 out_sda_drive_low;
  logic                 out_busy_res;
  logic [7:0]           out_read_data;
  logic                 out_read_valid;
  logic                 out_read_last;
  logic                 out_done_res;
  logic                 out_status;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [CFG_AW-1:0]    paddr = '0;
  logic [CFG_DW-1:0]    pwdata = '0;
  logic [CFG_DW-1:0]    prdata;
  logic                 pready;

  bus_scoreboard sb;
  bus_levels_t   got_levels;
  int            cycle_count = 0;
  int            ticks_sent = 0;
  int            results_seen = 0;
  int            rx_hold = 0;
  int            readback_errors = 0;
  int            settings_used = 0;
  bit            tx_pause_on = 1'b1;
  bit            rx_pause_on = 1'b1;

  i2c_master_register_access dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_start      (in_req_start),
    .in_func           (in_func),
    .in_slave_addr     (in_slave_addr),
    .in_sub_addr       (in_sub_addr),
    .in_write_data     (in_write_data),
    .in_read_count     (in_read_count),
    .in_sda_in         (in_sda_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scl_out       (out_scl_out),
    .out_sda_drive_low (out_sda_drive_low),
    .out_busy_res      (out_busy_res),
    .out_read_data     (out_read_data),
    .out_read_valid    (out_read_valid),
    .out_read_last     (out_read_last),
    .out_done_res      (out_done_res),
    .out_status        (out_status),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d ticks still awaited", cycle_count, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check every output transaction, then hold stall for a drawn count
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_levels.scl     = out_scl_out;
      got_levels.sda_low = out_sda_drive_low;
      got_levels.busy    = out_busy_res;
      got_levels.rdata   = out_read_data;
      got_levels.rvalid  = out_read_valid;
      got_levels.rlast   = out_read_last;
      got_levels.done    = out_done_res;
      got_levels.status  = out_status;
      sb.check_result(got_levels);
      results_seen++;
      if (results_seen % 64 == 0) rx_pause_on = ($urandom_range(0, 2) != 0);
      rx_hold = rx_pause_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (rx_hold > 0) out_stall <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
      if (rx_hold == 0) out_stall <= 1'b0;
    end
  end

  function automatic logic [CFG_AW-1:0] cfg_addr(logic idx);
    return CFG_AW'(idx) << 2;
  endfunction

  task automatic cfg_write(logic idx, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cfg_addr(idx);
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_config(idx, value);
    @(posedge clk);
  endtask

  task automatic cfg_expect(logic idx, logic [15:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= cfg_addr(idx);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(want)) begin
      readback_errors++;
      $display("%0t: register %0d readback, expected %0h, actual %0h", $time, idx, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_bus_timing(logic [15:0] half, logic [15:0] limit);
    cfg_write(REG_HALF, half);
    cfg_write(REG_TIMEOUT, limit);
    cfg_expect(REG_HALF, half);
    cfg_expect(REG_TIMEOUT, limit);
    settings_used++;
  endtask

  function automatic tick_in_t random_tick(int req_pct, int sda_pct);
    tick_in_t t;
    t.req_start  = ($urandom_range(0, 99) < req_pct);
    t.func       = 1'($urandom_range(0, 1));
    t.slave_addr = 7'($urandom_range(0, 127));
    t.sub_addr   = 8'($urandom_range(0, 255));
    t.write_data = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       t.read_count = 5'($urandom_range(0, 31));
      1:       t.read_count = 5'(MAX_READ_BYTES);
      default: t.read_count = 5'($urandom_range(1, 3));
    endcase
    t.sda_in     = ($urandom_range(0, 99) < sda_pct);
    return t;
  endfunction

  task automatic send_tick(tick_in_t t);
    int gap;
    ticks_sent++;
    if (ticks_sent % 64 == 0) tx_pause_on = ($urandom_range(0, 2) != 0);
    gap = tx_pause_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_start  <= t.req_start;
    in_func       <= t.func;
    in_slave_addr <= t.slave_addr;
    in_sub_addr   <= t.sub_addr;
    in_write_data <= t.write_data;
    in_read_count <= t.read_count;
    in_sda_in     <= t.sda_in;
    do @(posedge clk); while (in_stall);
    sb.note_input(t);
  endtask

  // keep ticking with no new request until the sequencer is back in idle
  task automatic finish_transfer(int sda_pct);
    while (!sb.engine_idle()) send_tick(random_tick(0, sda_pct));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_request(logic func, logic [6:0] dev, logic [7:0] ra, logic [7:0] wd,
                             logic [4:0] cnt, int sda_pct, bit poke_busy);
    tick_in_t t;
    t            = random_tick(0, sda_pct);
    t.req_start  = 1'b1;
    t.func       = func;
    t.slave_addr = dev;
    t.sub_addr   = ra;
    t.write_data = wd;
    t.read_count = cnt;
    send_tick(t);
    // a second request while the first runs must be dropped
    if (poke_busy) send_tick(random_tick(100, sda_pct));
    finish_transfer(sda_pct);
  endtask

  task automatic random_phase(logic [15:0] half, logic [15:0] limit, int count,
                              int req_pct, int sda_pct);
    settle();
    set_bus_timing(half, limit);
    repeat (count) send_tick(random_tick(req_pct, sda_pct));
    finish_transfer(sda_pct);
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values
    cfg_expect(REG_HALF, HALF_RESET);
    cfg_expect(REG_TIMEOUT, TIMEOUT_RESET);

    settle();
    set_bus_timing(16'd1, 16'd2);
    run_request(FUNC_WRITE, 7'h00, 8'h00, 8'h00, 5'd0, 20, 1'b0);
    run_request(FUNC_WRITE, 7'h7f, 8'hff, 8'hff, 5'd31, 20, 1'b0);
    run_request(FUNC_READ, 7'h00, 8'h00, 8'h00, 5'd0, 20, 1'b0);
    run_request(FUNC_READ, 7'h41, 8'h7e, 8'h5a, 5'd31, 30, 1'b1);
    run_request(FUNC_WRITE, 7'h12, 8'h34, 8'h56, 5'd3, 20, 1'b1);
    // slave never answers: timeout and stop
    run_request(FUNC_WRITE, 7'h3f, 8'h10, 8'hc3, 5'd1, 100, 1'b0);
    run_request(FUNC_READ, 7'h40, 8'hef, 8'h01, 5'd5, 100, 1'b0);

    random_phase(16'd1, 16'd1000, 30, 25, 30);
    random_phase(16'd0, 16'd0, 30, 25, 20);
    random_phase(16'd2, 16'd3, 30, 25, 50);
    random_phase(16'd1, 16'hffff, 30, 25, 60);
    random_phase(16'd3, 16'd1, 30, 25, 10);
    // full-scale timing: bus stays idle, no request issued
    random_phase(16'hffff, 16'hffff, 20, 0, 50);
    random_phase(16'd1, 16'd2, 30, 25, 40);

    settle();
    $display("checked %0d ticks over %0d timing settings, %0d readback errors",
             sb.ticks_checked, settings_used, readback_errors);
    $display("register writes %0d, burst reads %0d (%0d bytes), ack timeouts %0d",
             sb.writes_taken, sb.reads_taken, sb.bytes_read, sb.nacks_seen);
    if (sb.mismatches == 0 && readback_errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/i2cm_pkg.sv
hdl/i2cm_front.sv
hdl/i2cm_engine.sv
hdl/i2c_master_register_access.sv
hdl/i2cm_checker.sv
test/i2c_master_register_access_test.sv
